FILE: rtl/median_outlier_filter_top_assert.svh
// assertion macros for the median outlier filter
`ifndef MEDIAN_OUTLIER_FILTER_TOP_ASSERT_SVH
`define MEDIAN_OUTLIER_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define MOF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mof assertion failed");
`define MOF_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mof reset assertion failed");
`else
`define MOF_ASSERT(lbl, prop)
`define MOF_ASSERT_RST(lbl, prop)
`endif
`endif

FILE: rtl/mof_pkg.sv
// shared constants and types of the median outlier filter
`timescale 1ns / 1ps
package mof_pkg;

  localparam int unsigned DefMaxWindow = 7;
  localparam int unsigned DefMaxWidth  = 4096;
  localparam int unsigned DefPixelBits = 16;

  localparam int unsigned PixW   = 16;
  localparam int unsigned WidthW = 13;
  localparam int unsigned HeightW = 16;
  localparam int unsigned HalfW  = 2;
  localparam int unsigned ThrW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_HALF      = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  localparam logic [WidthW-1:0]  RstWidth  = 13'd1024;
  localparam logic [HeightW-1:0] RstHeight = 16'd1024;
  localparam logic [HalfW-1:0]   RstHalf   = 2'd1;
  localparam logic [ThrW-1:0]    RstThr    = 16'd768;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
  } rank_req_t;

endpackage

FILE: rtl/median_outlier_filter_top.sv
// top level of the conditional median filter with its line store
`timescale 1ns / 1ps
//
// channel  | signals                                       | direction
// in       | in_valid_i in_ready_o pixel_in_i flush_i      | sink
// out      | out_valid_o out_ready_i pixel_out_o replaced_o last_of_frame_o | source
// cfg      | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | sink
//
// a border result passes the centre pixel through; an interior result is ranked over n
// window pixels, n = (2*half_window+1)^2, and its pace is set by the single read port
// of the window memory in the rank unit
// results wait in an output register while the next transaction is taken
// reset clears control state only; the line store holds no reset value
// a geometry write, taken only when idle, drops held pixels and restarts counters
`include "median_outlier_filter_top_assert.svh"
module median_outlier_filter_top #(
  parameter int unsigned MAX_WINDOW = mof_pkg::DefMaxWindow,
  parameter int unsigned MAX_WIDTH  = mof_pkg::DefMaxWidth,
  parameter int unsigned PIXEL_BITS = mof_pkg::DefPixelBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mof_pkg::PixW-1:0]      pixel_in_i,
  input  logic                          flush_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mof_pkg::PixW-1:0]      pixel_out_o,
  output logic                          replaced_o,
  output logic                          last_of_frame_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mof_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mof_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned Ring = MAX_WINDOW * MAX_WIDTH;
  localparam int unsigned AW = $clog2(Ring);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned HB = $clog2(Ring + 1);
  localparam int unsigned WB = $clog2(MAX_WIDTH + 1);
  localparam int unsigned KMax = (MAX_WINDOW - 1) / 2;
  localparam int unsigned NB = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int unsigned PB = PIXEL_BITS;
  localparam int unsigned LW = PB + 9;
  localparam int unsigned CW = PB + mof_pkg::ThrW;
  localparam int unsigned HW = mof_pkg::HeightW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_CEN  = 8'b00000010,
    S_CAP  = 8'b00000100,
    S_LOAD = 8'b00001000,
    S_RANK = 8'b00010000,
    S_DEV  = 8'b00100000,
    S_CMP  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [mof_pkg::WidthW-1:0]  width_q;
  logic [mof_pkg::HeightW-1:0] height_q;
  logic [mof_pkg::HalfW-1:0]   half_q;
  logic [mof_pkg::ThrW-1:0]    thr_q;
  logic cfg_we, restart;

  logic [WB-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [mof_pkg::HalfW-1:0] k_eff;
  logic [HB-1:0] lag_w;
  logic [2:0] side_w;
  logic [NB-1:0] n_w;

  logic [PB-1:0] line_mem [Ring];
  logic [PB-1:0] rd_q;
  logic [AW-1:0] ra;
  logic line_we;

  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [HB-1:0] held_q, held_d;
  logic [WB-1:0] oc_q, oc_d;
  logic [HW-1:0] or_q, or_d;
  logic [PW-1:0] base_diff, start_diff, row_next_sum, addr_next_sum, wr_next_sum;
  logic [AW-1:0] base_w, start_w, base_q, base_d;
  logic border_w;

  logic [AW-1:0] addr_q, addr_d, row_q, row_d;
  logic [2:0] r_q, r_d, c_q, c_d;
  logic issue_q, issue_d, pend_q, pend_d;

  logic [PB-1:0] centre_q, centre_d, res_q, res_d;
  logic last_q, last_d, repl_q, repl_d;
  logic [LW-1:0] lhs_q, lhs_d;
  logic [CW-1:0] rhs_q, rhs_d;
  logic [PB-1:0] dev_w;

  mof_pkg::rank_req_t rk_req;
  logic rk_done;
  logic [PB-1:0] rk_q1, rk_med, rk_q3;

  logic in_acc, res_load;
  logic out_valid_q;
  logic [mof_pkg::PixW-1:0] out_pix_q;
  logic out_repl_q, out_last_q;

  // configuration
  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we = cfg_valid_i & cfg_ready_o;
  assign restart = cfg_we && (cfg_index_i != mof_pkg::CFG_THRESHOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= mof_pkg::RstWidth;
      height_q <= mof_pkg::RstHeight;
      half_q <= mof_pkg::RstHalf;
      thr_q <= mof_pkg::RstThr;
    end else if (cfg_we) begin
      unique case (mof_pkg::cfg_idx_e'(cfg_index_i))
        mof_pkg::CFG_WIDTH: width_q <= mof_pkg::WidthW'(cfg_data_i);
        mof_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        mof_pkg::CFG_HALF: half_q <= mof_pkg::HalfW'(cfg_data_i);
        mof_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective geometry
  always_comb begin
    if (width_q == '0) begin
      w_eff = WB'(1);
    end else if (int'(width_q) > int'(MAX_WIDTH)) begin
      w_eff = WB'(MAX_WIDTH);
    end else begin
      w_eff = WB'(width_q);
    end
    h_eff = (height_q == '0) ? HW'(1) : height_q;
    if (half_q == '0) begin
      k_eff = mof_pkg::HalfW'(1);
    end else if (int'(half_q) > int'(KMax)) begin
      k_eff = mof_pkg::HalfW'(KMax);
    end else begin
      k_eff = half_q;
    end
  end

  assign lag_w = HB'(HB'(k_eff) * HB'(w_eff)) + HB'(k_eff);
  assign side_w = {k_eff, 1'b1};
  assign n_w = NB'(NB'(side_w) * NB'(side_w));

  // ring addresses
  assign base_diff = PW'(wr_ptr_q) + PW'(Ring) - PW'(held_q);
  assign base_w = (base_diff >= PW'(Ring)) ? AW'(base_diff - PW'(Ring)) : AW'(base_diff);
  assign start_diff = PW'(base_q) + PW'(Ring) - PW'(lag_w);
  assign start_w = (start_diff >= PW'(Ring)) ? AW'(start_diff - PW'(Ring)) : AW'(start_diff);
  assign row_next_sum = PW'(row_q) + PW'(w_eff);
  assign addr_next_sum = PW'(addr_q) + PW'(1);
  assign wr_next_sum = PW'(wr_ptr_q) + PW'(1);

  assign border_w = (or_q < HW'(k_eff))
                 || ((HW + 1)'(or_q) + (HW + 1)'(k_eff) >= (HW + 1)'(h_eff))
                 || (oc_q < WB'(k_eff))
                 || ((WB + 1)'(oc_q) + (WB + 1)'(k_eff) >= (WB + 1)'(w_eff));

  // line store
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[wr_ptr_q] <= PB'(pixel_in_i);
    end
    rd_q <= line_mem[ra];
  end

  assign in_ready_o = (state_q == S_IDLE) && !cfg_valid_i;
  assign in_acc = in_valid_i & in_ready_o;
  assign dev_w = (centre_q > rk_med) ? PB'(centre_q - rk_med) : PB'(rk_med - centre_q);

  always_comb begin
    state_d = state_q;
    wr_ptr_d = wr_ptr_q;
    held_d = held_q;
    oc_d = oc_q;
    or_d = or_q;
    base_d = base_q;
    addr_d = addr_q;
    row_d = row_q;
    r_d = r_q;
    c_d = c_q;
    issue_d = issue_q;
    pend_d = 1'b0;
    centre_d = centre_q;
    res_d = res_q;
    last_d = last_q;
    repl_d = repl_q;
    lhs_d = lhs_q;
    rhs_d = rhs_q;
    line_we = 1'b0;
    ra = addr_q;
    rk_req = '0;
    res_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!flush_i) begin
            line_we = 1'b1;
            wr_ptr_d = (wr_next_sum >= PW'(Ring)) ? '0 : AW'(wr_next_sum);
            held_d = HB'(held_q + 1'b1);
            if (HB'(held_q + 1'b1) > lag_w) begin
              state_d = S_CEN;
            end
          end else if (held_q != '0 && border_w) begin
            state_d = S_CEN;
          end
        end
      end
      S_CEN: begin
        ra = base_w;
        base_d = base_w;
        state_d = S_CAP;
      end
      S_CAP: begin
        centre_d = rd_q;
        last_d = (or_q == HW'(h_eff - 1'b1)) && (oc_q == WB'(w_eff - 1'b1));
        held_d = HB'(held_q - 1'b1);
        if ((WB + 1)'(oc_q) + 1'b1 >= (WB + 1)'(w_eff)) begin
          oc_d = '0;
          or_d = ((HW + 1)'(or_q) + 1'b1 >= (HW + 1)'(h_eff)) ? '0 : HW'(or_q + 1'b1);
        end else begin
          oc_d = WB'(oc_q + 1'b1);
        end
        if (border_w) begin
          res_d = rd_q;
          repl_d = 1'b0;
          state_d = S_FIN;
        end else begin
          addr_d = start_w;
          row_d = start_w;
          r_d = '0;
          c_d = '0;
          issue_d = 1'b1;
          rk_req.clear = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (pend_q) begin
          rk_req.load = 1'b1;
        end
        if (issue_q) begin
          ra = addr_q;
          pend_d = 1'b1;
          if (c_q == side_w - 1'b1) begin
            c_d = '0;
            r_d = r_q + 1'b1;
            row_d = (row_next_sum >= PW'(Ring)) ? AW'(row_next_sum - PW'(Ring))
                                                : AW'(row_next_sum);
            addr_d = row_d;
            if (r_q == side_w - 1'b1) begin
              issue_d = 1'b0;
            end
          end else begin
            c_d = c_q + 1'b1;
            addr_d = (addr_next_sum >= PW'(Ring)) ? '0 : AW'(addr_next_sum);
          end
        end else if (pend_q) begin
          rk_req.start = 1'b1;
          state_d = S_RANK;
        end
      end
      S_RANK: begin
        if (rk_done) begin
          state_d = S_DEV;
        end
      end
      S_DEV: begin
        lhs_d = {dev_w, 9'd0};
        rhs_d = CW'(thr_q) * CW'(PB'(rk_q3 - rk_q1));
        state_d = S_CMP;
      end
      S_CMP: begin
        repl_d = (CW'(lhs_q) > rhs_q);
        res_d = (CW'(lhs_q) > rhs_q) ? rk_med : centre_q;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (restart) begin
      held_d = '0;
      oc_d = '0;
      or_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wr_ptr_q <= '0;
      held_q <= '0;
      oc_q <= '0;
      or_q <= '0;
      r_q <= '0;
      c_q <= '0;
      issue_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wr_ptr_q <= wr_ptr_d;
      held_q <= held_d;
      oc_q <= oc_d;
      or_q <= or_d;
      r_q <= r_d;
      c_q <= c_d;
      issue_q <= issue_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    addr_q <= addr_d;
    row_q <= row_d;
    centre_q <= centre_d;
    res_q <= res_d;
    last_q <= last_d;
    repl_q <= repl_d;
    lhs_q <= lhs_d;
    rhs_q <= rhs_d;
  end

  mof_rank #(
    .MAX_WINDOW (MAX_WINDOW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (rk_req),
    .wr_data_i (rd_q),
    .n_i       (n_w),
    .done_o    (rk_done),
    .q1_o      (rk_q1),
    .med_o     (rk_med),
    .q3_o      (rk_q3)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_pix_q <= mof_pkg::PixW'(res_q);
      out_repl_q <= repl_q;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign replaced_o = out_repl_q;
  assign last_of_frame_o = out_last_q;

  `MOF_ASSERT(a_wr_only_idle, line_we |-> state_q == S_IDLE)
  `MOF_ASSERT(a_held_bound, held_q <= lag_w + 1'b1)
  `MOF_ASSERT(a_load_free, res_load |-> (!out_valid_q || out_ready_i))
  `MOF_ASSERT(a_rank_done, rk_done |-> state_q == S_RANK)
  `MOF_ASSERT_RST(a_rst_out, !rst_ni |-> !out_valid_o)

endmodule

FILE: rtl/mof_rank.sv
// rank selection of q1, median and q3 over a window held in a small memory
`timescale 1ns / 1ps
module mof_rank #(
  parameter int unsigned MAX_WINDOW = mof_pkg::DefMaxWindow,
  parameter int unsigned PIXEL_BITS = mof_pkg::DefPixelBits
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  mof_pkg::rank_req_t                                 req_i,
  input  logic [PIXEL_BITS-1:0]                              wr_data_i,
  input  logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]         n_i,
  output logic                                               done_o,
  output logic [PIXEL_BITS-1:0]                              q1_o,
  output logic [PIXEL_BITS-1:0]                              med_o,
  output logic [PIXEL_BITS-1:0]                              q3_o
);

  localparam int unsigned MaxArea = MAX_WINDOW * MAX_WINDOW;
  localparam int unsigned IB = $clog2(MaxArea);
  localparam int unsigned NB = $clog2(MaxArea + 1);

  typedef enum logic [4:0] {
    R_IDLE  = 5'b00001,
    R_CAND  = 5'b00010,
    R_CCAP  = 5'b00100,
    R_SWEEP = 5'b01000,
    R_EVAL  = 5'b10000
  } rstate_e;

  rstate_e state_q, state_d;
  logic [PIXEL_BITS-1:0] win_mem [MaxArea];
  logic [PIXEL_BITS-1:0] rd_q, cand_q, cand_d;
  logic [IB-1:0] widx_q, ra;
  logic [NB-1:0] i_q, i_d, j_q, j_d, lt_q, lt_d, le_q, le_d;
  logic [NB-1:0] r1, r2, r3;
  logic [NB+1:0] n3;
  logic [PIXEL_BITS-1:0] q1_q, q1_d, med_q, med_d, q3_q, q3_d;
  logic done_q, done_d;

  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      win_mem[widx_q] <= wr_data_i;
    end
    rd_q <= win_mem[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
    end else if (req_i.clear) begin
      widx_q <= '0;
    end else if (req_i.load) begin
      widx_q <= IB'(widx_q + 1'b1);
    end
  end

  assign n3 = (NB+2)'(n_i) + ((NB+2)'(n_i) << 1);
  assign r1 = n_i >> 2;
  assign r2 = n_i >> 1;
  assign r3 = NB'(n3 >> 2);

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    lt_d = lt_q;
    le_d = le_q;
    cand_d = cand_q;
    q1_d = q1_q;
    med_d = med_q;
    q3_d = q3_q;
    done_d = 1'b0;
    ra = IB'(j_q);
    unique case (state_q)
      R_IDLE: begin
        if (req_i.start) begin
          i_d = '0;
          state_d = R_CAND;
        end
      end
      R_CAND: begin
        ra = IB'(i_q);
        state_d = R_CCAP;
      end
      R_CCAP: begin
        ra = '0;
        cand_d = rd_q;
        j_d = NB'(1);
        lt_d = '0;
        le_d = '0;
        state_d = R_SWEEP;
      end
      R_SWEEP: begin
        if (rd_q < cand_q) begin
          lt_d = NB'(lt_q + 1'b1);
        end
        if (rd_q <= cand_q) begin
          le_d = NB'(le_q + 1'b1);
        end
        if (j_q < n_i) begin
          ra = IB'(j_q);
          j_d = NB'(j_q + 1'b1);
        end else begin
          state_d = R_EVAL;
        end
      end
      R_EVAL: begin
        if (lt_q <= r1 && r1 < le_q) begin
          q1_d = cand_q;
        end
        if (lt_q <= r2 && r2 < le_q) begin
          med_d = cand_q;
        end
        if (lt_q <= r3 && r3 < le_q) begin
          q3_d = cand_q;
        end
        if (i_q == NB'(n_i - 1'b1)) begin
          done_d = 1'b1;
          state_d = R_IDLE;
        end else begin
          i_d = NB'(i_q + 1'b1);
          state_d = R_CAND;
        end
      end
      default: state_d = R_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      i_q <= '0;
      j_q <= '0;
      lt_q <= '0;
      le_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      lt_q <= lt_d;
      le_q <= le_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    q1_q <= q1_d;
    med_q <= med_d;
    q3_q <= q3_d;
  end

  assign done_o = done_q;
  assign q1_o = q1_q;
  assign med_o = med_q;
  assign q3_o = q3_q;

endmodule

FILE: dv/median_outlier_filter_top_tb.sv
// testbench of the median outlier filter: self-checking streams against a built-in predictor
`timescale 1ns / 1ps
module median_outlier_filter_top_tb;

  localparam int unsigned RingDepth = 7 * 4096;
  localparam int unsigned CycleLimit = 5000000;

  typedef struct packed {
    logic [mof_pkg::PixW-1:0] pix;
    logic                     repl;
    logic                     last;
  } filt_pixel_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b1;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [mof_pkg::PixW-1:0]     pixel_in_i = '0;
  logic                         flush_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [mof_pkg::PixW-1:0]     pixel_out_o;
  logic                         replaced_o;
  logic                         last_of_frame_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [mof_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mof_pkg::CfgDataW-1:0] cfg_data_i = '0;

  median_outlier_filter_top uut (.*);

  // predictor state
  logic [mof_pkg::PixW-1:0] px_ring [RingDepth];
  int unsigned      wr_ptr, held, out_col, out_row;
  int unsigned      reg_width, reg_height, reg_half, reg_thr;
  filt_pixel_t      filtered_q[$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned hold_cycles;
  int unsigned pixels_sent;
  bit          no_idle;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int unsigned eff_width();
    if (reg_width == 0) return 1;
    if (reg_width > 4096) return 4096;
    return reg_width;
  endfunction

  function automatic int unsigned eff_height();
    return (reg_height == 0) ? 1 : reg_height;
  endfunction

  function automatic int unsigned eff_half();
    if (reg_half == 0) return 1;
    if (reg_half > 3) return 3;
    return reg_half;
  endfunction

  function automatic bit oldest_is_border();
    int unsigned w, h, k;
    w = eff_width();
    h = eff_height();
    k = eff_half();
    return out_row < k || out_row + k >= h || out_col < k || out_col + k >= w;
  endfunction

  function automatic filt_pixel_t emit_oldest();
    int unsigned      w, h, k, side, n, base, start, cnt;
    logic [mof_pkg::PixW-1:0] win [49];
    logic [mof_pkg::PixW-1:0] v, centre, q1, med, q3;
    longint unsigned  dev, lhs, rhs;
    filt_pixel_t      res;
    int               j;
    w = eff_width();
    h = eff_height();
    k = eff_half();
    base = (wr_ptr + RingDepth - held) % RingDepth;
    centre = px_ring[base];
    res.pix = centre;
    res.repl = 1'b0;
    if (!oldest_is_border()) begin
      side = 2 * k + 1;
      n = side * side;
      start = (base + RingDepth - (k * w + k)) % RingDepth;
      cnt = 0;
      for (int r = 0; r < side; r++)
        for (int c = 0; c < side; c++) begin
          win[cnt] = px_ring[(start + r * w + c) % RingDepth];
          cnt++;
        end
      for (int i = 1; i < n; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      q1 = win[n/4];
      med = win[n/2];
      q3 = win[(3*n)/4];
      dev = (centre > med) ? centre - med : med - centre;
      lhs = dev * 512;
      rhs = longint'(reg_thr) * longint'(q3 - q1);
      if (lhs > rhs) begin
        res.pix = med;
        res.repl = 1'b1;
      end
    end
    res.last = (out_row == h - 1 && out_col == w - 1);
    held--;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    return res;
  endfunction

  task automatic predict_transaction(input logic [mof_pkg::PixW-1:0] pix, input logic fl);
    filt_pixel_t res;
    if (fl) begin
      if (held > 0 && oldest_is_border()) begin
        res = emit_oldest();
        filtered_q = {filtered_q, res};
      end
    end else begin
      px_ring[wr_ptr] = pix;
      wr_ptr = (wr_ptr + 1) % RingDepth;
      held++;
      if (held > eff_half() * eff_width() + eff_half()) begin
        res = emit_oldest();
        filtered_q = {filtered_q, res};
      end
    end
  endtask

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [mof_pkg::PixW-1:0] rand_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return mof_pkg::PixW'(30000 + $urandom_range(0, 200));
    if (sel < 75) return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
    return mof_pkg::PixW'($urandom);
  endfunction

  // called at a rising edge; returns at the edge of acceptance with valid still high
  task automatic send_item(input logic [mof_pkg::PixW-1:0] pix, input logic fl);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    flush_i <= fl;
    do @(posedge clk_i); while (!in_ready_o);
    predict_transaction(pix, fl);
    if (!fl) pixels_sent++;
  endtask

  // waits for every expected result and for the rank unit to go quiet
  task automatic settle();
    int unsigned n;
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    n = (2 * eff_half() + 1) * (2 * eff_half() + 1);
    repeat (n * (n + 3) + n + 40) @(posedge clk_i);
  endtask

  task automatic write_reg(input mof_pkg::cfg_idx_e idx,
                           input logic [mof_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mof_pkg::CFG_WIDTH:     reg_width = data & 16'h1fff;
      mof_pkg::CFG_HEIGHT:    reg_height = data;
      mof_pkg::CFG_HALF:      reg_half = data & 16'h3;
      mof_pkg::CFG_THRESHOLD: reg_thr = data;
      default: ;
    endcase
    if (idx != mof_pkg::CFG_THRESHOLD) begin
      held = 0;
      out_col = 0;
      out_row = 0;
    end
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h,
                              input int unsigned k, input int unsigned thr);
    settle();
    write_reg(mof_pkg::CFG_WIDTH, mof_pkg::CfgDataW'(w));
    write_reg(mof_pkg::CFG_HEIGHT, mof_pkg::CfgDataW'(h));
    write_reg(mof_pkg::CFG_HALF, mof_pkg::CfgDataW'(k));
    write_reg(mof_pkg::CFG_THRESHOLD, mof_pkg::CfgDataW'(thr));
  endtask

  task automatic drain();
    while (held > 0) begin
      if (oldest_is_border()) send_item('0, 1'b1);
      else send_item(rand_pixel(), 1'b0);
    end
  endtask

  // receiver and result checker
  initial begin
    int unsigned stall;
    filt_pixel_t exp_px;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0 || hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_cycles > 0) begin
          @(posedge clk_i);
          hold_cycles--;
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (filtered_q.size() == 0) begin
        report("result with no transaction waiting");
      end else begin
        exp_px = filtered_q.pop_front();
        if (pixel_out_o !== exp_px.pix)
          report($sformatf("pixel_out %0h, expected %0h", pixel_out_o, exp_px.pix));
        if (replaced_o !== exp_px.repl)
          report($sformatf("replaced %0b, expected %0b", replaced_o, exp_px.repl));
        if (last_of_frame_o !== exp_px.last)
          report($sformatf("last_of_frame %0b, expected %0b", last_of_frame_o, exp_px.last));
      end
    end
  end

  task automatic test_wide_border();
    set_geometry(8191, 0, 1, 768);
    send_item('0, 1'b1);
    for (int i = 0; i < 8; i++) send_item((i % 2) ? 16'hffff : 16'h0000, 1'b0);
    drain();
    set_geometry(0, 3, 0, 768);
    for (int i = 0; i < 6; i++) send_item(rand_pixel(), 1'b0);
    drain();
  endtask

  task automatic test_outlier_threshold();
    set_geometry(3, 3, 1, 0);
    for (int i = 0; i < 9; i++)
      send_item((i == 4) ? 16'hffff : mof_pkg::PixW'(100 + i), 1'b0);
    drain();
    set_geometry(3, 3, 1, 65535);
    for (int i = 0; i < 9; i++) send_item((i == 4) ? 16'd0 : 16'd500, 1'b0);
    drain();
    set_geometry(3, 3, 1, 65535);
    for (int i = 0; i < 9; i++) send_item(mof_pkg::PixW'(1000 + 1000 * i), 1'b0);
    drain();
  endtask

  task automatic test_largest_window();
    set_geometry(7, 7, 3, 256);
    for (int i = 0; i < 49; i++) send_item((i == 24) ? 16'h8000 : rand_pixel(), 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    set_geometry(4, 6, 1, 512);
    no_idle = 1'b1;
    hold_cycles = 400;
    for (int i = 0; i < 40; i++) send_item(rand_pixel(), 1'b0);
    no_idle = 1'b0;
    drain();
    settle();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, k, count, rows;
    while (pixels_sent < 950) begin
      k = ($urandom_range(0, 9) == 0) ? 2 : 1;
      w = $urandom_range(2 * k + 1, 12);
      h = ($urandom_range(0, 15) == 0) ? 65535 : $urandom_range(2 * k + 1, 10);
      set_geometry(w, h, k, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2048));
      no_idle = ($urandom_range(0, 3) == 0);
      rows = (h > 10) ? 10 : h;
      count = $urandom_range(w * rows / 2 + 1, 2 * w * rows);
      for (int i = 0; i < count; i++) begin
        if (pixels_sent % 97 == 0) begin
          settle();
          write_reg(mof_pkg::CFG_THRESHOLD, mof_pkg::CfgDataW'($urandom_range(0, 4096)));
        end
        if ($urandom_range(0, 9) == 0) send_item(mof_pkg::PixW'($urandom), 1'b1);
        else send_item(rand_pixel(), 1'b0);
      end
      no_idle = 1'b0;
      // tall frames are cut short; the next geometry write drops what is held
      if (h <= 10) drain();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    reg_width = mof_pkg::RstWidth;
    reg_height = mof_pkg::RstHeight;
    reg_half = mof_pkg::RstHalf;
    reg_thr = mof_pkg::RstThr;
    wr_ptr = 0;
    held = 0;
    out_col = 0;
    out_row = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_wide_border();
    test_outlier_threshold();
    test_largest_window();
    test_backpressure();
    test_random_frames();
    settle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: median_outlier_filter_top.f
+incdir+rtl
rtl/mof_pkg.sv
rtl/mof_rank.sv
rtl/median_outlier_filter_top.sv
dv/median_outlier_filter_top_tb.sv
